// ===== hdl/scalar_kalman_tracker_defines.svh =====
// assertion macros for the scalar kalman tracker
`ifndef SCALAR_KALMAN_TRACKER_DEFINES_SVH
`define SCALAR_KALMAN_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SKT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scalar kalman tracker check failed");

// next-cycle implication, checked outside reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scalar kalman tracker check failed");

`endif

// ===== hdl/skt_pkg.sv =====
// shared types, constants and a saturation helper for the kalman tracker
package skt_pkg;

  localparam int SAMPLE_W = 16;
  localparam int Q_W      = 32;
  localparam int GAIN_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 88;
  localparam int DIVD_W   = Q_W + 1;
  localparam int REM_W    = Q_W + 2;
  localparam int MUL_A_W  = Q_W + 2;
  localparam int MUL_ACC_W = MUL_A_W + 1;
  localparam int MUL_RES_W = MUL_ACC_W + 1;
  localparam int STEP_CNT_W = $clog2(GAIN_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

  localparam logic [Q_W-1:0]    PROCESS_NOISE_RST     = 32'd655;
  localparam logic [Q_W-1:0]    MEASUREMENT_NOISE_RST = 32'd65536;
  localparam logic [GAIN_W-1:0] GAIN_ONE              = 17'd65536;

  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic done;
  } unit_stat_t;

  function automatic logic [Q_W-1:0] sat_s32(input logic signed [MUL_RES_W-1:0] v);
    logic signed [MUL_RES_W-1:0] hi;
    logic signed [MUL_RES_W-1:0] lo;
    hi = MUL_RES_W'(32'sh7fffffff);
    lo = -MUL_RES_W'(33'sh080000000);
    if (v > hi) begin
      sat_s32 = 32'h7fffffff;
    end else if (v < lo) begin
      sat_s32 = 32'h80000000;
    end else begin
      sat_s32 = v[Q_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/skt_div.sv =====
// restoring divider, one gain bit per cycle: gain = num*2^16 / (num + den_add)
module skt_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  skt_pkg::unit_ctrl_t          ctrl,
  input  logic [skt_pkg::Q_W-1:0]      num,
  input  logic [skt_pkg::Q_W-1:0]      den_add,
  output skt_pkg::unit_stat_t          stat,
  output logic [skt_pkg::GAIN_W-1:0]   quotient
);
  import skt_pkg::*;

  logic [DIVD_W-1:0]     d_r;
  logic [REM_W-1:0]      r_r;
  logic [GAIN_W-1:0]     q_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic                  first_r;
  logic                  busy_r;
  logic                  done_r;
  logic [REM_W-1:0]      trial;
  logic [REM_W-1:0]      rest;
  logic                  fits;

  always_comb begin
    trial = first_r ? r_r : {r_r[REM_W-2:0], 1'b0};
    fits  = trial >= {1'b0, d_r};
    rest  = trial - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      first_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        d_r     <= {1'b0, num} + {1'b0, den_add};
        r_r     <= {2'b00, num};
        q_r     <= '0;
        cnt_r   <= STEP_CNT_W'(GAIN_W);
        first_r <= 1'b1;
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        r_r     <= fits ? rest : trial;
        q_r     <= {q_r[GAIN_W-2:0], fits};
        first_r <= 1'b0;
        cnt_r   <= cnt_r - 1'b1;
        if (cnt_r == STEP_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // zero divisor gives zero gain
  assign quotient  = (d_r == '0) ? '0 : q_r;
  assign stat.done = done_r;

endmodule

// ===== hdl/skt_mul.sv =====
// shift-and-add multiplier, one multiplier bit per cycle, result floored by 2^16
module skt_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  skt_pkg::unit_ctrl_t                 ctrl,
  input  logic signed [skt_pkg::MUL_A_W-1:0]  a,
  input  logic [skt_pkg::GAIN_W-1:0]          b,
  output skt_pkg::unit_stat_t                 stat,
  output logic signed [skt_pkg::MUL_RES_W-1:0] result
);
  import skt_pkg::*;

  logic signed [MUL_A_W-1:0]   a_r;
  logic [GAIN_W-1:0]           b_r;
  logic signed [MUL_ACC_W-1:0] acc_r;
  logic                        bit_r;
  logic [STEP_CNT_W-1:0]       cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic signed [MUL_ACC_W-1:0] sum;

  always_comb begin
    sum = acc_r + (b_r[0] ? {a_r[MUL_A_W-1], a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        bit_r  <= 1'b0;
        cnt_r  <= STEP_CNT_W'(GAIN_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        bit_r <= sum[0];
        acc_r <= sum >>> 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product bits 16 and up
  assign result    = {acc_r, bit_r};
  assign stat.done = done_r;

endmodule

// ===== hdl/scalar_kalman_tracker.sv =====
// scalar kalman tracker top level: control sequencer, state and stream ports
// requests are taken one at a time (in_tready only in idle); each runs the 17-step serial
// divider for the gain, then the two 17-step serial multipliers side by side
// a result waiting in the output register does not stop the next request from being
// accepted, but that request then waits in the update state until the register is free
// reset (rst_n low, synchronous) clears the state and restores the noise registers
module scalar_kalman_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [skt_pkg::SAMPLE_W-1:0]      in_tdata,   // [15:0] sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [skt_pkg::OUT_DATA_W-1:0]    out_tdata,  // [31:0] estimate, [63:32] variance,
                                                        // [80:64] gain, [87:81] zero
  input  logic                              cfg_wr_en,
  input  logic [skt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skt_pkg::Q_W-1:0]           cfg_data
);
  import skt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PRED, S_DIV_GO, S_DIV, S_MUL_GO, S_MUL, S_UPD
  } state_t;

  state_t                     state_r;
  logic [Q_W-1:0]             pn_r;
  logic [Q_W-1:0]             mn_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [Q_W-1:0]             mean_r;
  logic [Q_W-1:0]             var_r;
  logic [GAIN_W-1:0]          gain_r;
  logic [Q_W-1:0]             corr_r;
  logic [Q_W-1:0]             var_new_r;
  logic [Q_W-1:0]             mean_value_r;
  logic [Q_W-1:0]             last_corr_r;
  logic [Q_W-1:0]             err_var_r;
  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;

  unit_ctrl_t                 div_ctrl;
  unit_stat_t                 div_stat;
  unit_ctrl_t                 mul_ctrl;
  unit_stat_t                 corr_stat;
  unit_stat_t                 shrink_stat;
  logic [GAIN_W-1:0]          quot;
  logic signed [MUL_A_W-1:0]  diff;
  logic signed [MUL_A_W-1:0]  var_op;
  logic [GAIN_W-1:0]          keep;
  logic signed [MUL_RES_W-1:0] corr_prod;
  logic signed [MUL_RES_W-1:0] shrink_prod;
  logic signed [MUL_RES_W-1:0] pred_sum;
  logic [DIVD_W-1:0]          var_sum;
  logic signed [MUL_RES_W-1:0] upd_sum;
  logic [Q_W-1:0]             mean_next;
  logic                       out_free;

  always_comb begin
    div_ctrl.start = (state_r == S_DIV_GO);
    mul_ctrl.start = (state_r == S_MUL_GO);
    diff   = {{2{sample_r[SAMPLE_W-1]}}, sample_r, 16'b0}
           - {{2{mean_r[Q_W-1]}}, mean_r};
    var_op = {2'b00, var_r};
    keep   = GAIN_ONE - gain_r;
    pred_sum = MUL_RES_W'(signed'(mean_value_r)) + MUL_RES_W'(signed'(last_corr_r));
    var_sum  = {1'b0, err_var_r} + {1'b0, pn_r};
    upd_sum  = MUL_RES_W'(signed'(mean_r)) + MUL_RES_W'(signed'(corr_r));
    mean_next = sat_s32(upd_sum);
    out_free  = !out_valid_r || out_tready;
  end

  skt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .num      (var_r),
    .den_add  (mn_r),
    .stat     (div_stat),
    .quotient (quot)
  );

  // correction: (sample - estimate) * gain
  skt_mul u_mul_corr (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mul_ctrl),
    .a      (diff),
    .b      (gain_r),
    .stat   (corr_stat),
    .result (corr_prod)
  );

  // variance shrink: var * (1 - gain)
  skt_mul u_mul_shrink (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mul_ctrl),
    .a      (var_op),
    .b      (keep),
    .stat   (shrink_stat),
    .result (shrink_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r <= PROCESS_NOISE_RST;
      mn_r <= MEASUREMENT_NOISE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROCESS_NOISE:     pn_r <= cfg_data;
        REG_MEASUREMENT_NOISE: mn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mean_value_r <= '0;
      last_corr_r  <= '0;
      err_var_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_tready && state_r != S_UPD) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sample_r <= signed'(in_tdata);
            state_r  <= S_PRED;
          end
        end
        S_PRED: begin
          mean_r  <= sat_s32(pred_sum);
          var_r   <= var_sum[DIVD_W-1] ? '1 : var_sum[Q_W-1:0];
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: state_r <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            gain_r  <= quot;
            state_r <= S_MUL_GO;
          end
        end
        S_MUL_GO: state_r <= S_MUL;
        S_MUL: begin
          if (corr_stat.done && shrink_stat.done) begin
            corr_r    <= sat_s32(corr_prod);
            var_new_r <= shrink_prod[Q_W-1:0];
            state_r   <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            mean_value_r <= mean_next;
            last_corr_r  <= corr_r;
            err_var_r    <= var_new_r;
            out_data_r   <= {7'b0, gain_r, var_new_r, mean_next};
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/skt_checker.sv =====
// port-level checks for the kalman tracker, bound to the top level
`include "scalar_kalman_tracker_defines.svh"

module skt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [skt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import skt_pkg::*;

  // stalled result holds
  `SKT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, $stable(out_tdata))
  // one request at a time
  `SKT_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)
  // gain never above one
  `SKT_ASSERT_NOW(a_gain_range, out_tvalid, out_tdata[80:64] <= GAIN_ONE)
  // a fresh result comes with the sequencer back at idle
  `SKT_ASSERT_NOW(a_result_idle, $rose(out_tvalid), in_tready)

endmodule

bind scalar_kalman_tracker skt_checker u_skt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb.sv =====
// self-checking testbench for the scalar kalman tracker: directed table, then random phases
`timescale 1ns / 100ps

module tb;
  import skt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_REPORTS = 25;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [Q_W-1:0]    estimate;
    logic [Q_W-1:0]    variance;
    logic [GAIN_W-1:0] gain;
  } fused_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [Q_W-1:0]       value;
    logic [SAMPLE_W-1:0]  smp;
    logic                 typed;
    fused_t               want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;    // [15:0] sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [31:0] estimate, [63:32] variance,
                                           // [80:64] gain, [87:81] zero
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [Q_W-1:0]        cfg_data = '0;

  fused_t                fused_q [$];
  logic signed [Q_W-1:0] track_est;
  logic signed [Q_W-1:0] track_corr;
  logic [Q_W-1:0]        track_var;
  logic [Q_W-1:0]        noise_proc;
  logic [Q_W-1:0]        noise_meas;
  int                    track_centre;
  int                    err_count = 0;
  int                    reports = 0;
  int                    samples_sent = 0;
  int                    writes_done = 0;
  int                    results_seen = 0;
  rx_mode_t              rx_mode = RX_FREE;
  int                    rx_tick = 0;

  scalar_kalman_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // predict, gain, correct, shrink
  task automatic fuse_sample(input logic [SAMPLE_W-1:0] raw, output fused_t res);
    longint          smp;
    longint          pred_est;
    longint          diff;
    longint          corr;
    longint          est_new;
    longint unsigned v;
    longint unsigned divisor;
    longint unsigned g;
    smp = longint'($signed(raw));
    pred_est = clamp_s32(longint'(track_est) + longint'(track_corr));
    v = {32'd0, track_var} + {32'd0, noise_proc};
    if (v > 64'hffff_ffff) v = 64'hffff_ffff;
    divisor = v + {32'd0, noise_meas};
    g = (divisor == 0) ? 64'd0 : (v << 16) / divisor;
    diff = smp * 65536 - pred_est;
    corr = clamp_s32((diff * longint'(g)) >>> 16);
    est_new = clamp_s32(pred_est + corr);
    track_corr = corr[Q_W-1:0];
    track_est = est_new[Q_W-1:0];
    track_var = 32'((v * (64'd65536 - g)) >> 16);
    res.estimate = track_est;
    res.variance = track_var;
    res.gain = g[GAIN_W-1:0];
  endtask

  task automatic report_mismatch(input string what, input logic [Q_W-1:0] got,
                                 input logic [Q_W-1:0] want);
    err_count++;
    if (reports < MAX_REPORTS) begin
      $display("mismatch in %s: got %h, want %h at %0t", what, got, want, $realtime);
      reports++;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (fused_q.size() != 0) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic typed, input fused_t want);
    fused_t pred;
    in_tdata <= s;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fuse_sample(s, pred);
    fused_q.push_back(typed ? want : pred);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] val);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE:     noise_proc = val;
      REG_MEASUREMENT_NOISE: noise_meas = val;
      default: ;
    endcase
    writes_done++;
    @(posedge clk);
  endtask

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [Q_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = val;
    return r;
  endfunction

  function automatic plan_row_t smp_row(input logic [SAMPLE_W-1:0] s);
    plan_row_t r;
    r = '0;
    r.smp = s;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [SAMPLE_W-1:0] s, input logic [Q_W-1:0] est,
                                          input logic [Q_W-1:0] variance,
                                          input logic [GAIN_W-1:0] gain);
    plan_row_t r;
    r = '0;
    r.smp = s;
    r.typed = 1'b1;
    r.want.estimate = est;
    r.want.variance = variance;
    r.want.gain = gain;
    return r;
  endfunction

  function automatic logic [Q_W-1:0] pick_noise();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 32'hffff_ffff;
      2:       return $urandom_range(1, 2048);
      3:       return $urandom_range(32'h8000, 32'h4_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input bit tracking);
    int v;
    if (tracking && $urandom_range(0, 9) != 0) begin
      track_centre = track_centre + int'($urandom_range(0, 20)) - 10;
      v = track_centre + int'($urandom_range(0, 400)) - 200;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_W-1:0];
    end
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'(int'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_FREE:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_tready <= (rx_tick % 17) >= 6;
      default:     out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    fused_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (fused_q.size() == 0) begin
        report_mismatch("result without request", out_tdata[31:0], '0);
      end else begin
        want = fused_q.pop_front();
        if (out_tdata[31:0] !== want.estimate)
          report_mismatch("estimate", out_tdata[31:0], want.estimate);
        if (out_tdata[63:32] !== want.variance)
          report_mismatch("variance", out_tdata[63:32], want.variance);
        if (out_tdata[80:64] !== want.gain)
          report_mismatch("gain", 32'(out_tdata[80:64]), 32'(want.gain));
        if (out_tdata[87:81] !== '0)
          report_mismatch("padding", 32'(out_tdata[87:81]), '0);
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    plan_row_t row;
    int        burst_left;
    bit        phase_idles;
    bit        tracking;
    track_est = '0;
    track_corr = '0;
    track_var = '0;
    noise_proc = PROCESS_NOISE_RST;
    noise_meas = MEASUREMENT_NOISE_RST;
    track_centre = 0;
    plan = '{
      cfg_row(REG_PROCESS_NOISE, '0),
      typed_row(16'h7fff, '0, '0, '0),
      typed_row(16'h8000, '0, '0, '0),
      cfg_row(REG_MEASUREMENT_NOISE, '0),
      typed_row(16'h0001, '0, '0, '0),
      typed_row(16'hffff, '0, '0, '0),
      cfg_row(REG_PROCESS_NOISE, 32'h0001_0000),
      typed_row(16'h7fff, 32'h7fff_0000, '0, GAIN_ONE),
      smp_row(16'h8000),
      smp_row(16'h8000),
      smp_row(16'h7fff),
      cfg_row(REG_PROCESS_NOISE, 32'hffff_ffff),
      cfg_row(REG_MEASUREMENT_NOISE, 32'hffff_ffff),
      smp_row(16'h1234),
      smp_row(16'h8000),
      smp_row(16'h7fff),
      cfg_row(REG_MEASUREMENT_NOISE, '0),
      smp_row(16'h0000),
      smp_row(16'h7fff),
      cfg_row(REG_SPARE_2, 32'h5a5a_5a5a),
      cfg_row(REG_SPARE_3, 32'ha5a5_a5a5),
      smp_row(16'h8000),
      cfg_row(REG_PROCESS_NOISE, PROCESS_NOISE_RST),
      cfg_row(REG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RST),
      smp_row(16'h5555),
      smp_row(16'haaaa),
      smp_row(16'h0000),
      smp_row(16'h0001)
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        write_reg(row.idx, row.value);
      end else begin
        push_sample(row.smp, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        write_reg(REG_PROCESS_NOISE, pick_noise());
        write_reg(REG_MEASUREMENT_NOISE, pick_noise());
        if ($urandom_range(0, 2) == 0) write_reg((ph % 2) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
      end
      rx_mode = (ph == 0) ? RX_FREE : rx_mode_t'($urandom_range(0, 3));
      phase_idles = (ph != 0);
      tracking = ((ph % 2) != 0);
      track_centre = int'($urandom_range(0, 60000)) - 30000;
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end else if (phase_idles && burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          idle_gap($urandom_range(0, 12));
        end
        push_sample(pick_sample(tracking), 1'b0, '0);
        if (burst_left > 0) burst_left--;
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (fused_q.size() != 0) report_mismatch("requests left without result", fused_q.size(), '0);
    $display("covered %0d samples, %0d register writes, %0d results compared",
             samples_sent, writes_done, results_seen);
    $display("gain of zero and one, empty divisor, saturation and spare indexes included");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== scalar_kalman_tracker.f =====
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_div.sv
hdl/skt_mul.sv
hdl/scalar_kalman_tracker.sv
hdl/skt_checker.sv
tb/tb.sv
